// ===== hw/rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int BLOCK_W = 10;
  localparam int COUNT_W = 11;
  localparam int LINK_W  = BLOCK_W + 1;
  localparam int APB_AW  = 2;
  localparam int APB_DW  = 32;

  localparam logic [COUNT_W-1:0] POOL_BLOCKS_RESET = 11'd1024;
  localparam logic [APB_AW-1:0]  REG_POOL_BLOCKS   = 2'd0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [BLOCK_W-1:0] block;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] granted_block;
    logic               ok;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator with a LIFO free list and a bump counter.
// Request channel (req_valid, req_stall, req): op selects allocate or free;
// block names the block to free and is ignored on allocate.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, in order, with granted_block and ok.
// An allocate served from the free list reads the link of the head block from
// the link memory into a read register (rd_data) before the new head is known;
// a free, a fresh carve or a failed allocate is answered without that read.
// The response sits in an output register; the next request is taken in the
// same cycle that the previous response leaves. One request is in work at a
// time; no new request is taken while an allocate waits on the link read.
// While the receiver stalls, the response holds and req_stall stays high.
// Reset empties the free list, clears the carve counter and sets pool_blocks
// to 1024; the link memory is not cleared, as an entry is always written by
// a free before it can be read. pool_blocks is written through the APB port
// at address 0; the user must write it only while the block is idle, unchecked.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_BLOCKS);

  logic [LINK_W-1:0]  link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]  rd_data;

  state_t             state;
  logic [COUNT_W-1:0] pool_blocks;
  logic [BLOCK_W-1:0] free_head;
  logic               free_nonempty;
  logic [COUNT_W-1:0] next_unused;

  logic req_take;
  logic rsp_free;
  logic can_carve;
  logic free_in_range;
  logic from_list;
  logic mem_wr;
  logic rsp_load;

  assign pready   = 1'b1;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE) || !rsp_free;
  assign req_take  = req_valid && !req_stall;

  assign can_carve = (32'(next_unused) < 32'(pool_blocks)) &&
                     (32'(next_unused) < 32'(MAX_BLOCKS));
  assign free_in_range = 32'(req.block) < 32'(MAX_BLOCKS);
  assign from_list = req_take && (req.op == OP_ALLOC) && free_nonempty;
  assign mem_wr    = req_take && (req.op == OP_FREE) && free_in_range;
  assign rsp_load  = (state == ST_READ) || (req_take && !from_list);

  always_comb begin
    prdata = '0;
    if (paddr == REG_POOL_BLOCKS) begin
      prdata = APB_DW'(pool_blocks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= POOL_BLOCKS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_POOL_BLOCKS) begin
      pool_blocks <= pwdata[COUNT_W-1:0];
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      link_mem[AW'(req.block)] <= {free_nonempty, free_head};
    end
    if (from_list) begin
      rd_data <= link_mem[AW'(free_head)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      next_unused   <= '0;
      rsp_valid     <= 1'b0;
      rsp           <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (req.op == OP_FREE) begin
              rsp_valid <= 1'b1;
              rsp       <= '{granted_block: '0, ok: free_in_range};
              if (free_in_range) begin
                free_head     <= req.block;
                free_nonempty <= 1'b1;
              end
            end else if (free_nonempty) begin
              state <= ST_READ;
            end else begin
              rsp_valid <= 1'b1;
              if (can_carve) begin
                rsp         <= '{granted_block: next_unused[BLOCK_W-1:0], ok: 1'b1};
                next_unused <= next_unused + 1'b1;
              end else begin
                rsp <= '{granted_block: '0, ok: 1'b0};
              end
            end
          end
        end
        ST_READ: begin
          rsp_valid     <= 1'b1;
          rsp           <= '{granted_block: free_head, ok: 1'b1};
          free_head     <= rd_data[BLOCK_W-1:0];
          free_nonempty <= rd_data[BLOCK_W];
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !rsp_valid)
    else $error("link read returned while a response was pending");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.granted_block == '0)
    else $error("failed request carries a nonzero block");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    free_nonempty |-> 32'(free_head) < 32'(MAX_BLOCKS))
    else $error("free list head beyond storage");

  a_list_alloc_reads: assert property (@(posedge clk) disable iff (rst)
    req_take && req.op == OP_ALLOC && free_nonempty |=> state == ST_READ)
    else $error("list allocate did not wait for the link read");

endmodule
